// ----- sv/yaml_scalar_type_classifier_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef YAML_SCALAR_TYPE_CLASSIFIER_MACROS_SVH
`define YAML_SCALAR_TYPE_CLASSIFIER_MACROS_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define YSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define YSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ysc_pkg.sv -----
`timescale 1ns / 1ps

package ysc_pkg;

  localparam int KW_COUNT = 22;
  localparam int KW_TRUE  = 4;     // lower-case "true"
  localparam logic [7:0] NUL = 8'h00;

  typedef enum logic [2:0] {
    CLS_STR  = 3'd0,
    CLS_NULL = 3'd1,
    CLS_BOOL = 3'd2,
    CLS_DEC  = 3'd3,
    CLS_OCT  = 3'd4,
    CLS_HEX  = 3'd5,
    CLS_NUM  = 3'd6
  } class_t;

  typedef enum logic [2:0] {
    TAG_NONE  = 3'd0,
    TAG_STR   = 3'd1,
    TAG_NULL  = 3'd2,
    TAG_BOOL  = 3'd3,
    TAG_INT   = 3'd4,
    TAG_FLOAT = 3'd5,
    TAG_OTHER = 3'd6
  } tag_t;

  typedef enum logic [1:0] {
    DEC_START  = 2'd0,
    DEC_SIGN   = 2'd1,
    DEC_DIGITS = 2'd2,
    DEC_DEAD   = 2'd3
  } dec_phase_t;

  typedef enum logic [1:0] {
    PFX_PREFIX = 2'd0,
    PFX_DIGITS = 2'd1,
    PFX_DEAD   = 2'd3
  } pfx_phase_t;

  typedef enum logic [2:0] {
    FLT_START    = 3'd0,
    FLT_SIGN     = 3'd1,
    FLT_INT      = 3'd2,
    FLT_FRAC     = 3'd3,
    FLT_EXP      = 3'd4,
    FLT_EXP_SIGN = 3'd5,
    FLT_EXP_DIG  = 3'd6,
    FLT_DEAD     = 3'd7
  } flt_phase_t;

  // Keyword text, padded with NUL to eight bytes.
  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{"n", "u", "l", "l", NUL, NUL, NUL, NUL},
    '{"N", "u", "l", "l", NUL, NUL, NUL, NUL},
    '{"N", "U", "L", "L", NUL, NUL, NUL, NUL},
    '{"~", NUL, NUL, NUL, NUL, NUL, NUL, NUL},
    '{"t", "r", "u", "e", NUL, NUL, NUL, NUL},
    '{"T", "r", "u", "e", NUL, NUL, NUL, NUL},
    '{"T", "R", "U", "E", NUL, NUL, NUL, NUL},
    '{"f", "a", "l", "s", "e", NUL, NUL, NUL},
    '{"F", "a", "l", "s", "e", NUL, NUL, NUL},
    '{"F", "A", "L", "S", "E", NUL, NUL, NUL},
    '{".", "i", "n", "f", NUL, NUL, NUL, NUL},
    '{".", "I", "n", "f", NUL, NUL, NUL, NUL},
    '{".", "I", "N", "F", NUL, NUL, NUL, NUL},
    '{"-", ".", "i", "n", "f", NUL, NUL, NUL},
    '{"-", ".", "I", "n", "f", NUL, NUL, NUL},
    '{"-", ".", "I", "N", "F", NUL, NUL, NUL},
    '{"+", ".", "i", "n", "f", NUL, NUL, NUL},
    '{"+", ".", "I", "n", "f", NUL, NUL, NUL},
    '{"+", ".", "I", "N", "F", NUL, NUL, NUL},
    '{".", "n", "a", "n", NUL, NUL, NUL, NUL},
    '{".", "N", "a", "N", NUL, NUL, NUL, NUL},
    '{".", "N", "A", "N", NUL, NUL, NUL, NUL}
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd4, 3'd4, 3'd4, 3'd1, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd4,
    3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd4, 3'd4, 3'd4
  };

  localparam class_t KW_CLASS [KW_COUNT] = '{
    CLS_NULL, CLS_NULL, CLS_NULL, CLS_NULL,
    CLS_BOOL, CLS_BOOL, CLS_BOOL, CLS_BOOL, CLS_BOOL, CLS_BOOL,
    CLS_NUM, CLS_NUM, CLS_NUM, CLS_NUM, CLS_NUM, CLS_NUM,
    CLS_NUM, CLS_NUM, CLS_NUM, CLS_NUM, CLS_NUM, CLS_NUM
  };

  // true words only
  localparam logic [KW_COUNT-1:0] KW_BOOL = 22'h000070;

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == "+") || (c == "-");
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dig(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  // 0o / 0x prefix recognizer step.
  function automatic pfx_phase_t pfx_step(input pfx_phase_t ph, input logic [2:0] p,
                                          input logic [7:0] c, input logic [7:0] mark,
                                          input logic octal);
    logic ok;
    pfx_phase_t nx;
    ok = octal ? ((c >= "0") && (c <= "7")) : is_hex(c);
    nx = PFX_DEAD;
    case (ph)
      PFX_PREFIX: begin
        if (p == 3'd0) nx = (c == "0") ? PFX_PREFIX : PFX_DEAD;
        else if (p == 3'd1) nx = (c == mark) ? PFX_PREFIX : PFX_DEAD;
        else if (p == 3'd2) nx = ok ? PFX_DIGITS : PFX_DEAD;
      end
      PFX_DIGITS: nx = ok ? PFX_DIGITS : PFX_DEAD;
      default: nx = PFX_DEAD;
    endcase
    return nx;
  endfunction

endpackage

// ----- sv/ysc_in_if.sv -----
`timescale 1ns / 1ps

interface ysc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  logic       empty_req;
  logic       quoted;
  logic [2:0] tag_class;

  modport source (output valid, ch, last, empty_req, quoted, tag_class, input ready);
  modport sink (input valid, ch, last, empty_req, quoted, tag_class, output ready);
endinterface

// ----- sv/ysc_out_if.sv -----
`timescale 1ns / 1ps

interface ysc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] scalar_class;
  logic       bool_value;

  modport source (output valid, scalar_class, bool_value, input ready);
  modport sink (input valid, scalar_class, bool_value, output ready);
endinterface

// ----- sv/yaml_scalar_type_classifier.sv -----
// A closing word (last or empty_req) shows its result in the cycle after acceptance.
// One character word per cycle unless stalled; recognizers update in the accept cycle.
// The result register frees the input side, which stalls only while a result waits unread.
// Reset (rst, synchronous): result register empty, all recognizers back to their start state.
`timescale 1ns / 1ps

module yaml_scalar_type_classifier (
  input  logic clk,
  input  logic rst,
  ysc_in_if.sink    item,
  ysc_out_if.source result
);

  // Recognizer state for the scalar in progress.
  logic [2:0]                   pos;
  logic [ysc_pkg::KW_COUNT-1:0] cand;
  ysc_pkg::dec_phase_t          dec_ph;
  ysc_pkg::pfx_phase_t          oct_ph;
  ysc_pkg::pfx_phase_t          hex_ph;
  ysc_pkg::flt_phase_t          flt_ph;
  logic                         flt_dig;

  // State after taking the current character.
  logic [2:0]                   pos_next;
  logic [ysc_pkg::KW_COUNT-1:0] cand_next;
  ysc_pkg::dec_phase_t          dec_next;
  ysc_pkg::pfx_phase_t          oct_next;
  ysc_pkg::pfx_phase_t          hex_next;
  ysc_pkg::flt_phase_t          flt_next;
  logic                         flt_dig_next;
  logic                         true_exact;

  // Result register.
  logic                res_valid;
  ysc_pkg::class_t     res_class;
  logic                res_bool;
  ysc_pkg::class_t     cls;
  logic                bv;

  logic       accept;
  logic       closing;
  logic [7:0] c;
  ysc_pkg::tag_t tag;

  assign c       = item.ch;
  assign tag     = ysc_pkg::tag_t'(item.tag_class);
  assign accept  = item.valid && item.ready;
  assign closing = item.last || item.empty_req;

  // Input stalls only when a result is held and not taken this cycle.
  assign item.ready = !res_valid || result.ready;

  // Character step: every recognizer advances in parallel.
  always_comb begin
    for (int k = 0; k < ysc_pkg::KW_COUNT; k++) begin
      cand_next[k] = cand[k] && (pos < ysc_pkg::KW_LEN[k]) && (c == ysc_pkg::KW_TEXT[k][pos]);
    end
    // Text so far is exactly "true" once four characters matched.
    true_exact = (pos == 3'd3) && cand_next[ysc_pkg::KW_TRUE];

    case (dec_ph)
      ysc_pkg::DEC_START: begin
        if (ysc_pkg::is_sign(c)) dec_next = ysc_pkg::DEC_SIGN;
        else if ((c >= "1") && (c <= "9")) dec_next = ysc_pkg::DEC_DIGITS;
        else dec_next = ysc_pkg::DEC_DEAD;
      end
      ysc_pkg::DEC_SIGN:
        dec_next = ((c >= "1") && (c <= "9")) ? ysc_pkg::DEC_DIGITS : ysc_pkg::DEC_DEAD;
      ysc_pkg::DEC_DIGITS:
        dec_next = ysc_pkg::is_dig(c) ? ysc_pkg::DEC_DIGITS : ysc_pkg::DEC_DEAD;
      default: dec_next = ysc_pkg::DEC_DEAD;
    endcase

    oct_next = ysc_pkg::pfx_step(oct_ph, pos, c, "o", 1'b1);
    hex_next = ysc_pkg::pfx_step(hex_ph, pos, c, "x", 1'b0);

    flt_next     = flt_ph;
    flt_dig_next = flt_dig;
    case (flt_ph)
      ysc_pkg::FLT_START, ysc_pkg::FLT_SIGN: begin
        if ((flt_ph == ysc_pkg::FLT_START) && ysc_pkg::is_sign(c)) begin
          flt_next = ysc_pkg::FLT_SIGN;
        end else if (ysc_pkg::is_dig(c)) begin
          flt_next     = ysc_pkg::FLT_INT;
          flt_dig_next = 1'b1;
        end else if (c == ".") begin
          flt_next = ysc_pkg::FLT_FRAC;
        end else begin
          flt_next = ysc_pkg::FLT_DEAD;
        end
      end
      ysc_pkg::FLT_INT: begin
        if (ysc_pkg::is_dig(c)) flt_next = ysc_pkg::FLT_INT;
        else if (c == ".") flt_next = ysc_pkg::FLT_FRAC;
        else if ((c == "e") || (c == "E")) flt_next = ysc_pkg::FLT_EXP;
        else flt_next = ysc_pkg::FLT_DEAD;
      end
      ysc_pkg::FLT_FRAC: begin
        // exponent only once the mantissa holds a digit
        if (ysc_pkg::is_dig(c)) flt_dig_next = 1'b1;
        else if (((c == "e") || (c == "E")) && flt_dig) flt_next = ysc_pkg::FLT_EXP;
        else flt_next = ysc_pkg::FLT_DEAD;
      end
      ysc_pkg::FLT_EXP: begin
        if (ysc_pkg::is_sign(c)) flt_next = ysc_pkg::FLT_EXP_SIGN;
        else if (ysc_pkg::is_dig(c)) flt_next = ysc_pkg::FLT_EXP_DIG;
        else flt_next = ysc_pkg::FLT_DEAD;
      end
      ysc_pkg::FLT_EXP_SIGN, ysc_pkg::FLT_EXP_DIG:
        flt_next = ysc_pkg::is_dig(c) ? ysc_pkg::FLT_EXP_DIG : ysc_pkg::FLT_DEAD;
      default: flt_next = ysc_pkg::FLT_DEAD;
    endcase

    pos_next = (pos == 3'd7) ? pos : pos + 3'd1;
  end

  // Classification of the closing word, from the post-step state.
  // Quoted wins, then a known tag, then empty, keywords, and the number forms in order.
  always_comb begin
    logic found;
    found = 1'b0;
    cls   = ysc_pkg::CLS_STR;
    bv    = 1'b0;
    if (!item.quoted) begin
      case (tag)
        ysc_pkg::TAG_STR: cls = ysc_pkg::CLS_STR;
        ysc_pkg::TAG_NULL: cls = ysc_pkg::CLS_NULL;
        ysc_pkg::TAG_BOOL: begin
          cls = ysc_pkg::CLS_BOOL;
          bv  = !item.empty_req && true_exact;
        end
        ysc_pkg::TAG_INT, ysc_pkg::TAG_FLOAT: cls = ysc_pkg::CLS_NUM;
        default: begin
          // untagged, other tag, or unused code: judged by the text
          if (item.empty_req) begin
            cls = ysc_pkg::CLS_NULL;
          end else begin
            for (int k = 0; k < ysc_pkg::KW_COUNT; k++) begin
              if (!found && cand_next[k] && (ysc_pkg::KW_LEN[k] == pos_next)) begin
                cls   = ysc_pkg::KW_CLASS[k];
                bv    = ysc_pkg::KW_BOOL[k];
                found = 1'b1;
              end
            end
            if (!found) begin
              if (dec_next == ysc_pkg::DEC_DIGITS) cls = ysc_pkg::CLS_DEC;
              else if (oct_next == ysc_pkg::PFX_DIGITS) cls = ysc_pkg::CLS_OCT;
              else if (hex_next == ysc_pkg::PFX_DIGITS) cls = ysc_pkg::CLS_HEX;
              else if ((flt_next == ysc_pkg::FLT_EXP_DIG) || (flt_next == ysc_pkg::FLT_INT) ||
                       ((flt_next == ysc_pkg::FLT_FRAC) && flt_dig_next))
                cls = ysc_pkg::CLS_NUM;
            end
          end
        end
      endcase
    end
  end

  // Recognizer state: cleared at reset and after every closing word.
  always_ff @(posedge clk) begin
    if (rst || (accept && closing)) begin
      pos     <= 3'd0;
      cand    <= '1;
      dec_ph  <= ysc_pkg::DEC_START;
      oct_ph  <= ysc_pkg::PFX_PREFIX;
      hex_ph  <= ysc_pkg::PFX_PREFIX;
      flt_ph  <= ysc_pkg::FLT_START;
      flt_dig <= 1'b0;
    end else if (accept) begin
      pos     <= pos_next;
      cand    <= cand_next;
      dec_ph  <= dec_next;
      oct_ph  <= oct_next;
      hex_ph  <= hex_next;
      flt_ph  <= flt_next;
      flt_dig <= flt_dig_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && closing) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    if (accept && closing) begin
      res_class <= cls;
      res_bool  <= bv;
    end
  end

  assign result.valid        = res_valid;
  assign result.scalar_class = res_class;
  assign result.bool_value   = res_bool;

endmodule

// ----- sv/ysc_checker.sv -----
`timescale 1ns / 1ps
`include "yaml_scalar_type_classifier_macros.svh"

module ysc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       in_empty_req,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_class,
  input logic       out_bool
);

  logic in_acc;
  logic closing;
  logic out_free;

  assign in_acc   = in_valid && in_ready;
  assign closing  = in_last || in_empty_req;
  assign out_free = !out_valid || out_ready;

  `YSC_ASSERT_NEXT(a_close_gives_word, in_acc && closing, out_valid, "closing word gave no result")
  `YSC_ASSERT_NEXT(a_no_spurious_word, in_acc && !closing && out_free, !out_valid, "result without closing word")
  `YSC_ASSERT_NOW(a_bool_only_for_bool, out_valid && (out_class != ysc_pkg::CLS_BOOL), !out_bool, "bool_value set on non-bool class")
  `YSC_ASSERT_NOW(a_ready_when_free, out_free, in_ready, "input stalled with free result register")
  `YSC_ASSERT_NEXT(a_hold_result, out_valid && !out_ready, out_valid && $stable(out_class) && $stable(out_bool), "stalled result changed")

endmodule

bind yaml_scalar_type_classifier ysc_checker u_ysc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (item.valid),
  .in_ready     (item.ready),
  .in_last      (item.last),
  .in_empty_req (item.empty_req),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .out_class    (result.scalar_class),
  .out_bool     (result.bool_value)
);

// ----- verif/tb_yaml_scalar_type_classifier.sv -----
`timescale 1ns / 1ps

module tb_yaml_scalar_type_classifier;

  // Run length and pressure settings.
  localparam int RANDOM_WORDS = 1260;
  localparam int HOLD_CYCLES  = 300;
  localparam int BURST_WORDS  = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;

  // One expected result word.
  typedef struct packed {
    ysc_pkg::class_t cls;
    logic            bv;
  } class_verdict_t;

  // Scoreboard: tracks the recognizers the same way the block does and
  // queues one verdict per closing input word.
  class scalar_scoreboard;
    logic [2:0]                   pos;
    logic [ysc_pkg::KW_COUNT-1:0] live;
    ysc_pkg::dec_phase_t          dec;
    ysc_pkg::pfx_phase_t          oct;
    ysc_pkg::pfx_phase_t          hex;
    ysc_pkg::flt_phase_t          flt;
    logic                         digit_seen;
    logic                         true_exact;
    class_verdict_t               expected_classes[$];
    int                           errors;
    int                           reports;

    function new();
      errors  = 0;
      reports = 0;
      restart();
    endfunction

    function void restart();
      pos        = 3'd0;
      live       = '1;
      dec        = ysc_pkg::DEC_START;
      oct        = ysc_pkg::PFX_PREFIX;
      hex        = ysc_pkg::PFX_PREFIX;
      flt        = ysc_pkg::FLT_START;
      digit_seen = 1'b0;
      true_exact = 1'b0;
    endfunction

    static function string kw_word(int k);
      case (k)
        0: return "null";   1: return "Null";   2: return "NULL";   3: return "~";
        4: return "true";   5: return "True";   6: return "TRUE";
        7: return "false";  8: return "False";  9: return "FALSE";
        10: return ".inf";  11: return ".Inf";  12: return ".INF";
        13: return "-.inf"; 14: return "-.Inf"; 15: return "-.INF";
        16: return "+.inf"; 17: return "+.Inf"; 18: return "+.INF";
        19: return ".nan";  20: return ".NaN";  default: return ".NAN";
      endcase
    endfunction

    function logic digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
    endfunction

    function logic signch(logic [7:0] c);
      return (c == "+") || (c == "-");
    endfunction

    function logic hexch(logic [7:0] c);
      return digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    // 0o / 0x: '0' at position 0, mark at 1, then at least one digit.
    function ysc_pkg::pfx_phase_t prefix_next(ysc_pkg::pfx_phase_t ph, logic [7:0] c,
                                              logic [7:0] mark, logic octal);
      logic ok;
      ok = octal ? ((c >= "0") && (c <= "7")) : hexch(c);
      if (ph == ysc_pkg::PFX_DIGITS) return ok ? ysc_pkg::PFX_DIGITS : ysc_pkg::PFX_DEAD;
      if (ph != ysc_pkg::PFX_PREFIX) return ysc_pkg::PFX_DEAD;
      if (pos == 3'd0) return (c == "0") ? ysc_pkg::PFX_PREFIX : ysc_pkg::PFX_DEAD;
      if (pos == 3'd1) return (c == mark) ? ysc_pkg::PFX_PREFIX : ysc_pkg::PFX_DEAD;
      if (pos == 3'd2) return ok ? ysc_pkg::PFX_DIGITS : ysc_pkg::PFX_DEAD;
      return ysc_pkg::PFX_DEAD;
    endfunction

    function void advance_text(logic [7:0] c);
      string w;
      for (int k = 0; k < ysc_pkg::KW_COUNT; k++) begin
        w = kw_word(k);
        if (live[k] && ((pos >= w.len()) || (w[pos] != c))) live[k] = 1'b0;
      end
      true_exact = (pos == 3'd3) && live[ysc_pkg::KW_TRUE];

      case (dec)
        ysc_pkg::DEC_START: dec = signch(c) ? ysc_pkg::DEC_SIGN :
                                  ((c >= "1") && (c <= "9")) ? ysc_pkg::DEC_DIGITS :
                                  ysc_pkg::DEC_DEAD;
        ysc_pkg::DEC_SIGN:
          dec = ((c >= "1") && (c <= "9")) ? ysc_pkg::DEC_DIGITS : ysc_pkg::DEC_DEAD;
        ysc_pkg::DEC_DIGITS: dec = digit(c) ? ysc_pkg::DEC_DIGITS : ysc_pkg::DEC_DEAD;
        default: dec = ysc_pkg::DEC_DEAD;
      endcase

      oct = prefix_next(oct, c, "o", 1'b1);
      hex = prefix_next(hex, c, "x", 1'b0);

      case (flt)
        ysc_pkg::FLT_START, ysc_pkg::FLT_SIGN: begin
          if ((flt == ysc_pkg::FLT_START) && signch(c)) flt = ysc_pkg::FLT_SIGN;
          else if (digit(c)) begin
            flt = ysc_pkg::FLT_INT;
            digit_seen = 1'b1;
          end else if (c == ".") flt = ysc_pkg::FLT_FRAC;
          else flt = ysc_pkg::FLT_DEAD;
        end
        ysc_pkg::FLT_INT: begin
          if (digit(c)) flt = ysc_pkg::FLT_INT;
          else if (c == ".") flt = ysc_pkg::FLT_FRAC;
          else if ((c == "e") || (c == "E")) flt = ysc_pkg::FLT_EXP;
          else flt = ysc_pkg::FLT_DEAD;
        end
        ysc_pkg::FLT_FRAC: begin
          if (digit(c)) digit_seen = 1'b1;
          else if (((c == "e") || (c == "E")) && digit_seen) flt = ysc_pkg::FLT_EXP;
          else flt = ysc_pkg::FLT_DEAD;
        end
        ysc_pkg::FLT_EXP: flt = signch(c) ? ysc_pkg::FLT_EXP_SIGN :
                                digit(c) ? ysc_pkg::FLT_EXP_DIG : ysc_pkg::FLT_DEAD;
        ysc_pkg::FLT_EXP_SIGN, ysc_pkg::FLT_EXP_DIG:
          flt = digit(c) ? ysc_pkg::FLT_EXP_DIG : ysc_pkg::FLT_DEAD;
        default: flt = ysc_pkg::FLT_DEAD;
      endcase

      if (pos != 3'd7) pos = pos + 3'd1;
    endfunction

    function class_verdict_t resolve_class(logic quoted, logic [2:0] tag, logic empty);
      class_verdict_t v;
      string w;
      v.cls = ysc_pkg::CLS_STR;
      v.bv  = 1'b0;
      if (quoted) return v;
      case (tag)
        ysc_pkg::TAG_STR: return v;
        ysc_pkg::TAG_NULL: begin
          v.cls = ysc_pkg::CLS_NULL;
          return v;
        end
        ysc_pkg::TAG_BOOL: begin
          v.cls = ysc_pkg::CLS_BOOL;
          v.bv  = true_exact;
          return v;
        end
        ysc_pkg::TAG_INT, ysc_pkg::TAG_FLOAT: begin
          v.cls = ysc_pkg::CLS_NUM;
          return v;
        end
        default: ;
      endcase
      if (empty) begin
        v.cls = ysc_pkg::CLS_NULL;
        return v;
      end
      for (int k = 0; k < ysc_pkg::KW_COUNT; k++) begin
        w = kw_word(k);
        if (live[k] && (w.len() == pos)) begin
          v.cls = (k < 4) ? ysc_pkg::CLS_NULL : (k < 10) ? ysc_pkg::CLS_BOOL : ysc_pkg::CLS_NUM;
          v.bv  = (k >= 4) && (k < 7);
          return v;
        end
      end
      if (dec == ysc_pkg::DEC_DIGITS) v.cls = ysc_pkg::CLS_DEC;
      else if (oct == ysc_pkg::PFX_DIGITS) v.cls = ysc_pkg::CLS_OCT;
      else if (hex == ysc_pkg::PFX_DIGITS) v.cls = ysc_pkg::CLS_HEX;
      else if ((flt == ysc_pkg::FLT_EXP_DIG) || (flt == ysc_pkg::FLT_INT) ||
               ((flt == ysc_pkg::FLT_FRAC) && digit_seen))
        v.cls = ysc_pkg::CLS_NUM;
      return v;
    endfunction

    function void note_word(logic [7:0] c, logic last, logic empty, logic quoted,
                            logic [2:0] tag);
      if (empty) restart();
      else begin
        advance_text(c);
        if (!last) return;
      end
      expected_classes.push_back(resolve_class(quoted, tag, empty));
      restart();
    endfunction

    function void check_result(logic [2:0] cls, logic bv);
      class_verdict_t exp;
      if (expected_classes.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("unexpected result word: class %0d bool %0d", cls, bv);
        end
        return;
      end
      exp = expected_classes.pop_front();
      if ((cls !== exp.cls) || (bv !== exp.bv)) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("result mismatch: class exp %0d got %0d, bool exp %0d got %0d",
                   exp.cls, cls, exp.bv, bv);
        end
      end
    endfunction

    function int waiting();
      return expected_classes.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  ysc_in_if  item_bus ();
  ysc_out_if result_bus ();

  yaml_scalar_type_classifier uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus)
  );

  scalar_scoreboard board;

  int          idle_pct = 0;   // sender: % of cycles left idle before a word
  int          stall_pct = 0;  // receiver: % of cycles with ready low
  int          hold_requests = 0;
  int          holds_served = 0;
  int          words_sent = 0;
  int unsigned cycle_count = 0;
  logic [7:0]  text_buf[$];    // bytes of the next scalar

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_yaml_scalar_type_classifier NOT OK");
      $finish;
    end
  end

  // Monitor: both channels sampled at the edge, pre-update values only.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_bus.valid && result_bus.ready)
        board.check_result(result_bus.scalar_class, result_bus.bool_value);
      if (item_bus.valid && item_bus.ready)
        board.note_word(item_bus.ch, item_bus.last, item_bus.empty_req, item_bus.quoted,
                        item_bus.tag_class);
    end
  end

  // Receiver: random stalls per phase; a hold request drops ready for a long
  // stretch so a result sits unread and the input side backs up.
  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          result_bus.ready <= 1'b0;
          @(posedge clk);
        end
      end
      result_bus.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  // Drive one word and hold it until the block takes it. Called on a rising edge,
  // returns on the edge at which the word went in.
  task automatic send_word(input logic [7:0] c, input logic last, input logic empty,
                           input logic quoted, input logic [2:0] tag);
    while ((idle_pct != 0) && ($urandom_range(99) < idle_pct)) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid     <= 1'b1;
    item_bus.ch        <= c;
    item_bus.last      <= last;
    item_bus.empty_req <= empty;
    item_bus.quoted    <= quoted;
    item_bus.tag_class <= tag;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    words_sent++;
  endtask

  // Send text_buf as one scalar. Quoted and tag only matter on the closing word,
  // so earlier words carry junk there. An empty buffer becomes an empty request.
  task automatic send_scalar(input logic quoted, input logic [2:0] tag);
    int n;
    n = text_buf.size();
    if (n == 0)
      send_word(8'($urandom_range(255)), ($urandom_range(9) != 0), 1'b1, quoted, tag);
    else
      for (int i = 0; i < n; i++) begin
        if (i == n - 1) send_word(text_buf[i], 1'b1, 1'b0, quoted, tag);
        else send_word(text_buf[i], 1'b0, 1'b0, 1'($urandom_range(1)),
                       3'($urandom_range(7)));
      end
  endtask

  function automatic void load_text(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick(input string pool);
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  task automatic send_text(input string s, input logic quoted, input logic [2:0] tag);
    load_text(s);
    send_scalar(quoted, tag);
  endtask

  // Mostly well-formed numbers and keywords, some near misses, some noise.
  function automatic void build_random_text();
    int kind;
    int n;
    kind = $urandom_range(99);
    text_buf.delete();
    if (kind < 15) begin
      load_text(scalar_scoreboard::kw_word($urandom_range(ysc_pkg::KW_COUNT - 1)));
      if ($urandom_range(4) == 0) begin
        if ($urandom_range(1) == 0) text_buf.push_back(pick("eEsnfl0."));
        else text_buf[$urandom_range(text_buf.size() - 1)] = pick("nNuUlLeEaA.~-+");
      end
    end else if (kind < 30) begin
      if ($urandom_range(2) == 0) text_buf.push_back(pick("+-"));
      text_buf.push_back(($urandom_range(9) == 0) ? 8'("0") : pick("123456789"));
      n = $urandom_range(6);
      repeat (n) text_buf.push_back(pick("0123456789"));
    end else if (kind < 38) begin
      text_buf.push_back("0");
      text_buf.push_back("o");
      n = $urandom_range(1, 4);
      repeat (n) text_buf.push_back(($urandom_range(9) == 0) ? pick("89a") : pick("01234567"));
    end else if (kind < 46) begin
      text_buf.push_back("0");
      text_buf.push_back("x");
      n = $urandom_range(1, 4);
      repeat (n) text_buf.push_back(($urandom_range(11) == 0) ? pick("gG.") :
                                    pick("0123456789abcdefABCDEF"));
    end else if (kind < 62) begin
      if ($urandom_range(2) == 0) text_buf.push_back(pick("+-"));
      n = $urandom_range(3);
      repeat (n) text_buf.push_back(pick("0123456789"));
      if ($urandom_range(1) == 0) text_buf.push_back(".");
      n = $urandom_range(3);
      repeat (n) text_buf.push_back(pick("0123456789"));
      if ($urandom_range(2) == 0) begin
        text_buf.push_back(pick("eE"));
        if ($urandom_range(1) == 0) text_buf.push_back(pick("+-"));
        n = $urandom_range(2);
        repeat (n) text_buf.push_back(pick("0123456789"));
      end
    end else if (kind < 80) begin
      n = $urandom_range(1, 8);
      repeat (n) text_buf.push_back(pick("0123456789+-.eEoxabfnulstrINFNaA~ "));
    end else if (kind < 93) begin
      n = $urandom_range(1, 10);
      repeat (n) text_buf.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic send_random_scalar();
    logic       quoted;
    logic [2:0] tag;
    int         cut;
    build_random_text();
    quoted = ($urandom_range(9) == 0);
    tag    = ($urandom_range(9) < 7) ? 3'(ysc_pkg::TAG_NONE) : 3'($urandom_range(7));
    // now and then a scalar is abandoned midway by an empty request
    if ((text_buf.size() > 1) && ($urandom_range(29) == 0)) begin
      cut = $urandom_range(1, text_buf.size() - 1);
      for (int i = 0; i < cut; i++)
        send_word(text_buf[i], 1'b0, 1'b0, 1'($urandom_range(1)), 3'($urandom_range(7)));
      text_buf.delete();
    end
    send_scalar(quoted, tag);
  endtask

  task automatic run_directed();
    // keywords of each kind
    send_text("null", 1'b0, ysc_pkg::TAG_NONE);
    send_text("~", 1'b0, ysc_pkg::TAG_NONE);
    send_text("TRUE", 1'b0, ysc_pkg::TAG_NONE);
    send_text("False", 1'b0, ysc_pkg::TAG_NONE);
    send_text("-.Inf", 1'b0, ysc_pkg::TAG_NONE);
    send_text(".NaN", 1'b0, ysc_pkg::TAG_NONE);
    // integers, lone zero, prefixed forms
    send_text("-45", 1'b0, ysc_pkg::TAG_NONE);
    send_text("0", 1'b0, ysc_pkg::TAG_NONE);
    send_text("007", 1'b0, ysc_pkg::TAG_NONE);
    send_text("0o17", 1'b0, ysc_pkg::TAG_NONE);
    send_text("0x1F", 1'b0, ysc_pkg::TAG_NONE);
    // floats, and a mantissa with no digit
    send_text("1.5e-3", 1'b0, ysc_pkg::TAG_NONE);
    send_text(".5", 1'b0, ysc_pkg::TAG_NONE);
    send_text(".e5", 1'b0, ysc_pkg::TAG_NONE);
    // long text saturates the position
    send_text("abcdefghij", 1'b0, ysc_pkg::TAG_NONE);
    // quoting and tags
    send_text("42", 1'b1, ysc_pkg::TAG_NONE);
    send_text("null", 1'b0, ysc_pkg::TAG_STR);
    send_text("x", 1'b0, ysc_pkg::TAG_NULL);
    send_text("true", 1'b0, ysc_pkg::TAG_BOOL);
    send_text("True", 1'b0, ysc_pkg::TAG_BOOL);
    send_text("zz", 1'b0, ysc_pkg::TAG_INT);
    send_text("q", 1'b0, ysc_pkg::TAG_FLOAT);
    send_text("42", 1'b0, ysc_pkg::TAG_OTHER);
    send_text(".INF", 1'b0, 3'd7);
    // empty requests, one of them dropping a partial scalar
    send_text("", 1'b0, ysc_pkg::TAG_NONE);
    send_text("", 1'b0, ysc_pkg::TAG_BOOL);
    send_word("t", 1'b0, 1'b0, 1'b1, ysc_pkg::TAG_STR);
    send_word(8'hFF, 1'b1, 1'b1, 1'b0, ysc_pkg::TAG_NONE);
    // extreme bytes
    text_buf.delete();
    text_buf.push_back(8'h00);
    text_buf.push_back(8'hFF);
    send_scalar(1'b0, ysc_pkg::TAG_NONE);
  endtask

  initial begin
    int base;
    board = new();
    rst                <= 1'b1;
    item_bus.valid     <= 1'b0;
    item_bus.ch        <= 8'h00;
    item_bus.last      <= 1'b0;
    item_bus.empty_req <= 1'b0;
    item_bus.quoted    <= 1'b0;
    item_bus.tag_class <= ysc_pkg::TAG_NONE;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    base = words_sent;

    // no idling at all
    idle_pct  = 0;
    stall_pct = 0;
    while (words_sent < base + 300) send_random_scalar();

    // long receiver hold while the sender keeps offering words
    hold_requests++;
    while (words_sent < base + 300 + BURST_WORDS) send_random_scalar();

    // sender gaps only
    idle_pct  = 52;
    stall_pct = 0;
    while (words_sent < base + 650) send_random_scalar();

    // receiver stalls only
    idle_pct  = 0;
    stall_pct = 52;
    while (words_sent < base + 1000) send_random_scalar();

    // both
    idle_pct  = 27;
    stall_pct = 27;
    while (words_sent < base + RANDOM_WORDS) send_random_scalar();
    item_bus.valid <= 1'b0;

    // drain, then wait out any stray result word
    while (board.waiting() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (board.errors == 0) $display("tb_yaml_scalar_type_classifier OK");
    else $display("tb_yaml_scalar_type_classifier NOT OK");
    $finish;
  end

endmodule
